### design/icg_pkg.sv
// ----------------------------------------------------------------------------
// icg_pkg
// Shared constants, types and helpers of the password candidate generator.
// ----------------------------------------------------------------------------
package icg_pkg;

  localparam int MaxKeyLen    = 8;
  localparam int AlphabetSize = 95;
  localparam int Rows         = AlphabetSize + 1;
  localparam int TriTables    = MaxKeyLen - 2;
  localparam int TriSize      = Rows * Rows * Rows;

  localparam int FirstAw = $clog2(Rows);
  localparam int PairAw  = $clog2(Rows * Rows);
  localparam int TriAw   = $clog2(TriTables * TriSize);
  localparam int PosW    = $clog2(MaxKeyLen);
  localparam int KeyW    = 8 * MaxKeyLen;
  localparam int CharsW  = $clog2(MaxKeyLen + 1);
  localparam int DigitW  = 7;
  localparam int CfgW    = 7;

  localparam logic [7:0] CharBase = 8'h20;

  // input commands
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_DIGIT = 2'd1;
  localparam logic [1:0] CMD_GEN   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_KEY_LEN = 2'd0;
  localparam logic [1:0] REG_FIXED   = 2'd1;
  localparam logic [1:0] REG_COUNT   = 2'd2;

  typedef enum logic [2:0] {
    OP_WR_FIRST = 3'd0,
    OP_WR_PAIR  = 3'd1,
    OP_WR_TRI   = 3'd2,
    OP_DIGIT    = 3'd3,
    OP_GEN      = 3'd4
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [TriAw-1:0]  addr;
    logic [7:0]        data;
    logic [PosW-1:0]   digit;
  } qent_t;

  typedef struct packed {
    logic [PosW-1:0]   len;
    logic [PosW-1:0]   fixed;
    logic [DigitW-1:0] count;
  } cfg_t;

  // table row of a character, wraps modulo 256
  function automatic logic [7:0] row_of(input logic [7:0] c);
    return c - CharBase;
  endfunction

endpackage

### design/icg_ram.sv
// ----------------------------------------------------------------------------
// icg_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module icg_ram #(
  parameter int Width = 8,
  parameter int Depth = 96
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // write or read one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### design/icg_front.sv
// ----------------------------------------------------------------------------
// icg_front
// Accepts input items, drops meaningless ones and turns table writes into
// flat memory addresses.
// ----------------------------------------------------------------------------
module icg_front (
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_command,
  input  logic [2:0]            in_table_select,
  input  logic [6:0]            in_prev_two_index,
  input  logic [6:0]            in_prev_one_index,
  input  logic [6:0]            in_slot,
  input  logic [2:0]            in_digit_index,
  input  logic [7:0]            in_value,
  input  logic                  q_full,
  output logic                  push,
  output icg_pkg::qent_t        push_ent
);

  logic                       keep;
  logic [2:0]                 tsel;
  logic [icg_pkg::TriAw-1:0]  p1_w;
  logic [icg_pkg::TriAw-1:0]  p2_w;
  logic [icg_pkg::TriAw-1:0]  slot_w;
  logic [icg_pkg::TriAw-1:0]  rows_w;

  assign p1_w   = icg_pkg::TriAw'(in_prev_one_index);
  assign p2_w   = icg_pkg::TriAw'(in_prev_two_index);
  assign slot_w = icg_pkg::TriAw'(in_slot);
  assign rows_w = icg_pkg::TriAw'(icg_pkg::Rows);
  assign tsel   = in_table_select - 3'd2;

  // classify the item and form its address
  always_comb begin
    keep           = 1'b0;
    push_ent.op    = icg_pkg::OP_GEN;
    push_ent.addr  = '0;
    push_ent.data  = in_value;
    push_ent.digit = icg_pkg::PosW'(in_digit_index);
    case (in_command)
      icg_pkg::CMD_WRITE: begin
        if (in_table_select == 3'd0) begin
          keep          = (32'(in_slot) < icg_pkg::Rows);
          push_ent.op   = icg_pkg::OP_WR_FIRST;
          push_ent.addr = slot_w;
        end else if (in_table_select == 3'd1) begin
          keep          = (32'(in_slot) < icg_pkg::Rows) &&
                          (32'(in_prev_one_index) < icg_pkg::Rows);
          push_ent.op   = icg_pkg::OP_WR_PAIR;
          push_ent.addr = p1_w * rows_w + slot_w;
        end else begin
          keep          = (32'(in_slot) < icg_pkg::Rows) &&
                          (32'(in_prev_one_index) < icg_pkg::Rows) &&
                          (32'(in_prev_two_index) < icg_pkg::Rows) &&
                          (32'(tsel) < icg_pkg::TriTables);
          push_ent.op   = icg_pkg::OP_WR_TRI;
          push_ent.addr = icg_pkg::TriAw'(tsel) * icg_pkg::TriAw'(icg_pkg::TriSize)
                          + (p2_w * rows_w + p1_w) * rows_w + slot_w;
        end
      end
      icg_pkg::CMD_DIGIT: begin
        keep        = (32'(in_digit_index) < icg_pkg::MaxKeyLen);
        push_ent.op = icg_pkg::OP_DIGIT;
      end
      icg_pkg::CMD_GEN: begin
        keep        = 1'b1;
        push_ent.op = icg_pkg::OP_GEN;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready && keep;

endmodule

### design/icg_queue.sv
// ----------------------------------------------------------------------------
// icg_queue
// Two-entry queue between the front and the back part.
// ----------------------------------------------------------------------------
module icg_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  icg_pkg::qent_t push_ent,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output icg_pkg::qent_t q_ent
);

  icg_pkg::qent_t mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           do_pop;

  assign do_pop  = pop && (count_r != 2'd0);
  assign full    = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_ent   = mem_r[rd_ptr_r];

  // advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // hold entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_ent;
    end
  end

endmodule

### design/icg_back.sv
// ----------------------------------------------------------------------------
// icg_back
// Executes queued items: table writes, digit writes, and key generation by
// chained table reads and, past one character, a digit-serial counter advance.
// ----------------------------------------------------------------------------
module icg_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  icg_pkg::cfg_t               cfg,
  input  logic                        q_valid,
  input  icg_pkg::qent_t              q_ent,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [icg_pkg::KeyW-1:0]    out_key,
  output logic [icg_pkg::CharsW-1:0]  out_key_chars,
  output logic                        out_last
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOOK = 5'b00010,
    S_CAPT = 5'b00100,
    S_ADV  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [icg_pkg::PosW-1:0]        pos_r, pos_nxt;
  logic [icg_pkg::PosW-1:0]        idx_r, idx_nxt;
  logic [icg_pkg::DigitW-1:0]      dig_r [icg_pkg::MaxKeyLen];
  logic [icg_pkg::DigitW-1:0]      dig_nxt [icg_pkg::MaxKeyLen];
  logic [7:0]                      prev1_r, prev1_nxt;
  logic [7:0]                      prev2_r, prev2_nxt;
  logic [icg_pkg::KeyW-1:0]        key_r, key_nxt;
  logic                            zero_r, zero_nxt;
  logic                            last_r, last_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [icg_pkg::KeyW-1:0]        out_key_r, out_key_nxt;
  logic [icg_pkg::CharsW-1:0]      out_chars_r, out_chars_nxt;
  logic                            out_last_r, out_last_nxt;

  logic [icg_pkg::DigitW-1:0]      d;
  logic [7:0]                      a1;
  logic [7:0]                      a2;
  logic                            look_oor;
  logic [icg_pkg::TriAw-1:0]       look_addr;
  logic [icg_pkg::TriAw-1:0]       ram_addr;
  logic [icg_pkg::TriAw-1:0]       rows_w;
  logic                            we_first, we_pair, we_tri;
  logic [7:0]                      rd_first, rd_pair, rd_tri;
  logic [7:0]                      rd_sel;
  logic [7:0]                      ch;
  logic [7:0]                      v;
  logic                            adv_ok;

  assign d      = dig_r[idx_r];
  assign a1     = icg_pkg::row_of(prev1_r);
  assign a2     = icg_pkg::row_of(prev2_r);
  assign rows_w = icg_pkg::TriAw'(icg_pkg::Rows);

  // lookup address of the current key position
  always_comb begin
    if (pos_r == '0) begin
      look_oor  = (32'(d) >= icg_pkg::Rows);
      look_addr = icg_pkg::TriAw'(d);
    end else if (pos_r == icg_pkg::PosW'(1)) begin
      look_oor  = (32'(a1) >= icg_pkg::Rows) || (32'(d) >= icg_pkg::Rows);
      look_addr = icg_pkg::TriAw'(a1) * rows_w + icg_pkg::TriAw'(d);
    end else begin
      look_oor  = (32'(a2) >= icg_pkg::Rows) || (32'(a1) >= icg_pkg::Rows) ||
                  (32'(d) >= icg_pkg::Rows);
      look_addr = icg_pkg::TriAw'(pos_r - icg_pkg::PosW'(2))
                  * icg_pkg::TriAw'(icg_pkg::TriSize)
                  + (icg_pkg::TriAw'(a2) * rows_w + icg_pkg::TriAw'(a1)) * rows_w
                  + icg_pkg::TriAw'(d);
    end
  end

  assign ram_addr = (state_r == S_IDLE) ? q_ent.addr : look_addr;
  assign we_first = (state_r == S_IDLE) && q_valid && (q_ent.op == icg_pkg::OP_WR_FIRST);
  assign we_pair  = (state_r == S_IDLE) && q_valid && (q_ent.op == icg_pkg::OP_WR_PAIR);
  assign we_tri   = (state_r == S_IDLE) && q_valid && (q_ent.op == icg_pkg::OP_WR_TRI);

  icg_ram #(.Width(8), .Depth(icg_pkg::Rows)) u_first (
    .clk   (clk),
    .we    (we_first),
    .addr  (ram_addr[icg_pkg::FirstAw-1:0]),
    .wdata (q_ent.data),
    .rdata (rd_first)
  );

  icg_ram #(.Width(8), .Depth(icg_pkg::Rows * icg_pkg::Rows)) u_pair (
    .clk   (clk),
    .we    (we_pair),
    .addr  (ram_addr[icg_pkg::PairAw-1:0]),
    .wdata (q_ent.data),
    .rdata (rd_pair)
  );

  icg_ram #(.Width(8), .Depth(icg_pkg::TriTables * icg_pkg::TriSize)) u_tri (
    .clk   (clk),
    .we    (we_tri),
    .addr  (ram_addr),
    .wdata (q_ent.data),
    .rdata (rd_tri)
  );

  // pick the table that served this position
  always_comb begin
    if (pos_r == '0) begin
      rd_sel = rd_first;
    end else if (pos_r == icg_pkg::PosW'(1)) begin
      rd_sel = rd_pair;
    end else begin
      rd_sel = rd_tri;
    end
  end

  assign ch     = zero_r ? 8'd0 : rd_sel;
  assign v      = {1'b0, d} + 8'd1;
  assign adv_ok = (idx_r > cfg.fixed) ? (v <= {1'b0, cfg.count}) : (v < {1'b0, cfg.count});

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    dig_nxt       = dig_r;
    prev1_nxt     = prev1_r;
    prev2_nxt     = prev2_r;
    key_nxt       = key_r;
    zero_nxt      = zero_r;
    last_nxt      = last_r;
    out_key_nxt   = out_key_r;
    out_chars_nxt = out_chars_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    q_pop         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_ent.op)
            icg_pkg::OP_DIGIT: begin
              dig_nxt[q_ent.digit] = q_ent.data[icg_pkg::DigitW-1:0];
            end
            icg_pkg::OP_GEN: begin
              dig_nxt[cfg.fixed] = cfg.count;
              key_nxt            = '0;
              pos_nxt            = '0;
              idx_nxt            = '0;
              prev1_nxt          = '0;
              prev2_nxt          = '0;
              state_nxt          = S_LOOK;
            end
            default: begin
            end
          endcase
        end
      end
      S_LOOK: begin
        zero_nxt  = look_oor;
        state_nxt = S_CAPT;
      end
      S_CAPT: begin
        key_nxt[{pos_r, 3'b000} +: 8] = ch;
        prev2_nxt = prev1_r;
        prev1_nxt = ch;
        if (pos_r == cfg.len) begin
          if (cfg.len > cfg.fixed) begin
            idx_nxt   = cfg.len;
            state_nxt = S_ADV;
          end else if (cfg.len == '0) begin
            last_nxt  = 1'b1;
            state_nxt = S_EMIT;
          end else begin
            idx_nxt   = cfg.len - icg_pkg::PosW'(1);
            state_nxt = S_ADV;
          end
        end else begin
          pos_nxt   = pos_r + icg_pkg::PosW'(1);
          idx_nxt   = pos_r + icg_pkg::PosW'(1);
          state_nxt = S_LOOK;
        end
      end
      S_ADV: begin
        if (idx_r != cfg.fixed && adv_ok) begin
          dig_nxt[idx_r] = v[icg_pkg::DigitW-1:0];
          last_nxt       = 1'b0;
          state_nxt      = S_EMIT;
        end else begin
          if (idx_r != cfg.fixed) begin
            dig_nxt[idx_r] = '0;
          end
          if (idx_r == '0) begin
            last_nxt  = 1'b1;
            state_nxt = S_EMIT;
          end else begin
            idx_nxt = idx_r - icg_pkg::PosW'(1);
          end
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_key_nxt   = key_r;
          out_chars_nxt = icg_pkg::CharsW'(cfg.len) + icg_pkg::CharsW'(1);
          out_last_nxt  = last_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state and counter digits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < icg_pkg::MaxKeyLen; i++) begin
        dig_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      dig_r       <= dig_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    idx_r       <= idx_nxt;
    prev1_r     <= prev1_nxt;
    prev2_r     <= prev2_nxt;
    key_r       <= key_nxt;
    zero_r      <= zero_nxt;
    last_r      <= last_nxt;
    out_key_r   <= out_key_nxt;
    out_chars_r <= out_chars_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_key       = out_key_r;
  assign out_key_chars = out_chars_r;
  assign out_last      = out_last_r;

endmodule

### design/incremental_password_candidate_gen.sv
// Flow: a write or digit item is executed by the back part as it pops from the queue;
// a generate item is popped, then each key character takes a table read state and a
// capture state, then the counter advances digit by digit (not for a one-character
// key), then the key is emitted once the output register is free. The back part takes
// no new item until then; the input takes an item per cycle until the two-entry
// queue fills. Sync reset clears control state, digits, configuration and queue.
// ----------------------------------------------------------------------------
// incremental_password_candidate_gen
// Password candidate generator: character tables, mixed-radix digit counter.
// ----------------------------------------------------------------------------
module incremental_password_candidate_gen (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [icg_pkg::CfgW-1:0]    cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_command,
  input  logic [2:0]                  in_table_select,
  input  logic [6:0]                  in_prev_two_index,
  input  logic [6:0]                  in_prev_one_index,
  input  logic [6:0]                  in_slot,
  input  logic [2:0]                  in_digit_index,
  input  logic [7:0]                  in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [icg_pkg::KeyW-1:0]    out_key,
  output logic [icg_pkg::CharsW-1:0]  out_key_chars,
  output logic                        out_last
);

  icg_pkg::cfg_t  cfg_r, cfg_nxt;
  logic           q_full;
  logic           push;
  icg_pkg::qent_t push_ent;
  logic           q_pop;
  logic           q_valid;
  icg_pkg::qent_t q_ent;

  // decode configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        icg_pkg::REG_KEY_LEN: cfg_nxt.len   = cfg_wdata[icg_pkg::PosW-1:0];
        icg_pkg::REG_FIXED:   cfg_nxt.fixed = cfg_wdata[icg_pkg::PosW-1:0];
        icg_pkg::REG_COUNT:   cfg_nxt.count = cfg_wdata[icg_pkg::DigitW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  icg_front u_front (
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_table_select   (in_table_select),
    .in_prev_two_index (in_prev_two_index),
    .in_prev_one_index (in_prev_one_index),
    .in_slot           (in_slot),
    .in_digit_index    (in_digit_index),
    .in_value          (in_value),
    .q_full            (q_full),
    .push              (push),
    .push_ent          (push_ent)
  );

  icg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_ent    (q_ent)
  );

  icg_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_valid       (q_valid),
    .q_ent         (q_ent),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_key       (out_key),
    .out_key_chars (out_key_chars),
    .out_last      (out_last)
  );

endmodule

### design/icg_checker.sv
// ----------------------------------------------------------------------------
// icg_checker
// Port-level checks of the generator's result channel.
// ----------------------------------------------------------------------------
module icg_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [icg_pkg::KeyW-1:0]    out_key,
  input logic [icg_pkg::CharsW-1:0]  out_key_chars,
  input logic                        out_last
);

  // stalled result holds valid, key and last flag
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_key) && $stable(out_last))
    else $error("result changed while stalled");

  // character count in range
  a_chars: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_key_chars != '0) &&
                  (32'(out_key_chars) <= icg_pkg::MaxKeyLen))
    else $error("key_chars out of range");

  // single-character key has clear upper bytes
  a_upper: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_key_chars == icg_pkg::CharsW'(1)) |-> (out_key[icg_pkg::KeyW-1:8] == '0))
    else $error("bytes above the key are not clear");

  // no result right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind incremental_password_candidate_gen icg_checker u_chk (.*);

### bench/incremental_password_candidate_gen_tb.sv
// ----------------------------------------------------------------------------
// incremental_password_candidate_gen_tb
// Drives table writes, digit sets and key generate items through the input
// channel, predicts each key, its length and the wrap flag from a local model
// of the character stores and digit counter, and checks every result in
// order. Before each generate the bench writes any table byte the key will
// read that was never written, so no undefined byte is ever read.
// ----------------------------------------------------------------------------
module incremental_password_candidate_gen_tb;

  localparam int         CycleLimit = 1000000;
  localparam int         PairBase   = 96;
  localparam int         TriBase    = 96 + 96 * 96;
  localparam logic [1:0] CmdUnknown = 2'd3;

  typedef struct packed {
    logic [63:0] key;
    logic [3:0]  chars;
    logic        last;
  } key_result_t;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [1:0]                 cfg_index;
  logic [icg_pkg::CfgW-1:0]   cfg_wdata;
  logic                       in_valid;
  logic                       in_ready;
  logic [1:0]                 in_command;
  logic [2:0]                 in_table_select;
  logic [6:0]                 in_prev_two_index;
  logic [6:0]                 in_prev_one_index;
  logic [6:0]                 in_slot;
  logic [2:0]                 in_digit_index;
  logic [7:0]                 in_value;
  logic                       out_valid;
  logic                       out_ready;
  logic [icg_pkg::KeyW-1:0]   out_key;
  logic [icg_pkg::CharsW-1:0] out_key_chars;
  logic                       out_last;

  // model state
  logic [7:0]  table_bytes[int];
  logic [6:0]  digits[8];
  logic [2:0]  len_reg;
  logic [2:0]  fixed_reg;
  logic [6:0]  count_reg;

  key_result_t pending_keys[$];
  int          fail_count;
  int          cycles;
  bit          calm;
  logic        rx_hold;
  int          rx_wait;

  incremental_password_candidate_gen dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_table_select(in_table_select),
    .in_prev_two_index(in_prev_two_index), .in_prev_one_index(in_prev_one_index),
    .in_slot(in_slot), .in_digit_index(in_digit_index), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_key(out_key), .out_key_chars(out_key_chars), .out_last(out_last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // table address of the byte read for key position p
  function automatic bit locate(input int p, input logic [7:0] c2, input logic [7:0] c1,
                                input logic [6:0] d, output int idx);
    logic [7:0] a;
    logic [7:0] b;
    a = c2 - icg_pkg::CharBase;
    b = c1 - icg_pkg::CharBase;
    idx = 0;
    if (d >= icg_pkg::Rows) return 0;
    if (p == 0) begin
      idx = d;
      return 1;
    end
    if (p == 1) begin
      if (b >= icg_pkg::Rows) return 0;
      idx = PairBase + b * icg_pkg::Rows + d;
      return 1;
    end
    if (a >= icg_pkg::Rows || b >= icg_pkg::Rows) return 0;
    idx = TriBase + (p - 2) * icg_pkg::TriSize + (a * icg_pkg::Rows + b) * icg_pkg::Rows + d;
    return 1;
  endfunction

  function automatic logic [7:0] read_char(input int p, input logic [7:0] c2,
                                           input logic [7:0] c1, input logic [6:0] d);
    int idx;
    if (locate(p, c2, c1, d, idx) && table_bytes.exists(idx)) return table_bytes[idx];
    return 8'd0;
  endfunction

  // build the key from the digits, then advance the counter
  function automatic key_result_t next_key();
    int len, fx, cnt, p, pos, v;
    bit done;
    logic [7:0] c[8];
    key_result_t r;
    len = len_reg;
    fx = fixed_reg;
    cnt = count_reg;
    done = 0;
    r.key = '0;
    digits[fx] = count_reg;
    for (p = 0; p < 8; p++) c[p] = 8'd0;
    for (p = 0; p <= len; p++) begin
      c[p] = read_char(p, (p >= 2) ? c[p-2] : 8'd0, (p >= 1) ? c[p-1] : 8'd0, digits[p]);
      r.key[8*p +: 8] = c[p];
    end
    pos = len;
    if (fx < len) begin
      v = digits[len] + 1;
      if (v <= cnt) begin
        digits[len] = v[6:0];
        done = 1;
      end else begin
        digits[len] = '0;
        pos = len - 1;
        while (pos > fx) begin
          v = digits[pos] + 1;
          if (v <= cnt) begin
            digits[pos] = v[6:0];
            done = 1;
            break;
          end
          digits[pos] = '0;
          pos--;
        end
      end
    end
    while (!done && pos > 0) begin
      pos--;
      v = digits[pos] + 1;
      if (v < cnt) begin
        digits[pos] = v[6:0];
        done = 1;
      end else begin
        digits[pos] = '0;
      end
    end
    r.chars = 4'(len + 1);
    r.last = !done;
    return r;
  endfunction

  // update the model with one accepted item
  function automatic void apply_item(input logic [1:0] cmd, input logic [2:0] sel,
                                     input logic [6:0] p2, input logic [6:0] p1,
                                     input logic [6:0] slot, input logic [2:0] di,
                                     input logic [7:0] val);
    if (cmd == icg_pkg::CMD_WRITE) begin
      if (slot >= icg_pkg::Rows) return;
      if (sel == 0) table_bytes[slot] = val;
      else if (sel == 1) begin
        if (p1 < icg_pkg::Rows) table_bytes[PairBase + p1 * icg_pkg::Rows + slot] = val;
      end else if (p2 < icg_pkg::Rows && p1 < icg_pkg::Rows) begin
        table_bytes[TriBase + (sel - 2) * icg_pkg::TriSize +
                    (p2 * icg_pkg::Rows + p1) * icg_pkg::Rows + slot] = val;
      end
    end else if (cmd == icg_pkg::CMD_DIGIT) begin
      digits[di] = val[6:0];
    end else if (cmd == icg_pkg::CMD_GEN) begin
      pending_keys.push_back(next_key());
    end
  endfunction

  // offer one item after a random gap and hold it until accepted
  task automatic send_item(input logic [1:0] cmd, input logic [2:0] sel,
                           input logic [6:0] p2, input logic [6:0] p1,
                           input logic [6:0] slot, input logic [2:0] di,
                           input logic [7:0] val);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_table_select <= sel;
    in_prev_two_index <= p2;
    in_prev_one_index <= p1;
    in_slot <= slot;
    in_digit_index <= di;
    in_value <= val;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    apply_item(cmd, sel, p2, p1, slot, di, val);
  endtask

  // character byte for a table: mostly a small alphabet, sometimes anything
  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return icg_pkg::CharBase + 8'($urandom_range(0, 5));
  endfunction

  // write every unwritten byte the next key reads, then generate it
  task automatic gen_key();
    int p, idx;
    logic [6:0] d[8];
    logic [7:0] c[8];
    logic [7:0] c2;
    logic [7:0] c1;
    d = digits;
    d[fixed_reg] = count_reg;
    for (p = 0; p <= len_reg; p++) begin
      c2 = (p >= 2) ? c[p-2] : 8'd0;
      c1 = (p >= 1) ? c[p-1] : 8'd0;
      if (locate(p, c2, c1, d[p], idx) && !table_bytes.exists(idx))
        send_item(icg_pkg::CMD_WRITE, 3'(p), 7'(c2 - icg_pkg::CharBase),
                  7'(c1 - icg_pkg::CharBase), d[p], 3'($urandom_range(0, 7)), pick_char());
      c[p] = read_char(p, c2, c1, d[p]);
    end
    send_item(icg_pkg::CMD_GEN, 3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)),
              7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
              3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
  endtask

  // drop valid and wait until every key is back and the block is quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_keys.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == icg_pkg::REG_KEY_LEN) len_reg = val[2:0];
    else if (idx == icg_pkg::REG_FIXED) fixed_reg = val[2:0];
    else if (idx == icg_pkg::REG_COUNT) count_reg = val;
  endtask

  task automatic configure(input int len, input int fx, input int cnt);
    drain();
    write_reg(icg_pkg::REG_KEY_LEN, 7'(len));
    write_reg(icg_pkg::REG_FIXED, 7'(fx));
    write_reg(icg_pkg::REG_COUNT, 7'(cnt));
    cfg_we <= 1'b0;
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) gen_key();
    else if (pick < 80)
      send_item(icg_pkg::CMD_WRITE, 3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)),
                7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                3'($urandom_range(0, 7)), pick_char());
    else if (pick < 95)
      send_item(icg_pkg::CMD_DIGIT, 3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)),
                7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                3'($urandom_range(0, 7)),
                ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, count_reg + 1)));
    else
      send_item(CmdUnknown, 3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)),
                7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
  endtask

  // extremes of the fields, every command and each corner case
  task automatic test_directed();
    configure(2, 0, 2);
    // writes outside the tables are dropped, the last slot of the first table is kept
    send_item(icg_pkg::CMD_WRITE, 3'd0, 7'd0, 7'd0, 7'd96, 3'd0, 8'hFF);
    send_item(icg_pkg::CMD_WRITE, 3'd1, 7'd0, 7'd96, 7'd0, 3'd0, 8'hFF);
    send_item(icg_pkg::CMD_WRITE, 3'd7, 7'd127, 7'd0, 7'd0, 3'd0, 8'hFF);
    send_item(icg_pkg::CMD_WRITE, 3'd0, 7'd127, 7'd127, 7'd95, 3'd7, 8'h7E);
    // unknown command
    send_item(CmdUnknown, 3'd7, 7'd127, 7'd127, 7'd127, 3'd7, 8'hFF);
    gen_key();
    gen_key();
    // character whose row is past the tables
    send_item(icg_pkg::CMD_WRITE, 3'd0, 7'd0, 7'd0, 7'd1, 3'd0, 8'h10);
    send_item(icg_pkg::CMD_DIGIT, 3'd0, 7'd0, 7'd0, 7'd0, 3'd0, 8'd1);
    gen_key();
    // digit past the tables, top value bit dropped
    send_item(icg_pkg::CMD_DIGIT, 3'd0, 7'd0, 7'd0, 7'd0, 3'd1, 8'hFF);
    gen_key();
    send_item(icg_pkg::CMD_DIGIT, 3'd0, 7'd0, 7'd0, 7'd0, 3'd2, 8'h80);
    gen_key();
    // fixed position past the key
    configure(1, 7, 3);
    repeat (6) gen_key();
  endtask

  task automatic test_config_sweep();
    int s, k;
    int lens[6] = '{0, 7, 3, 7, 0, 5};
    int fixes[6] = '{0, 7, 7, 0, 3, 2};
    int counts[6] = '{0, 94, 1, 2, 94, 3};
    for (s = 0; s < 6; s++) begin
      configure(lens[s], fixes[s], counts[s]);
      for (k = 0; k < 30; k++) random_item();
    end
  endtask

  task automatic test_random();
    int k;
    for (k = 0; k < 900; k++) begin
      if (k % 150 == 0) configure($urandom_range(0, 7), $urandom_range(0, 7),
                                  $urandom_range(1, 4));
      if (k % 200 == 100) calm = 1;
      if (k % 200 == 140) calm = 0;
      random_item();
    end
  endtask

  // stall the result side for a long stretch while items keep coming,
  // then pause the input until everything is back
  task automatic test_backpressure();
    int k;
    configure(3, 1, 2);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (400) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    for (k = 0; k < 30; k++) gen_key();
    in_valid <= 1'b0;
    while (pending_keys.size() != 0) @(posedge clk);
    for (k = 0; k < 20; k++) random_item();
  endtask

  // accept and check results
  always @(posedge clk) begin
    int w;
    key_result_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait <= 0;
    end else begin
      w = (rx_wait > 0) ? rx_wait - 1 : 0;
      if (out_valid && out_ready) begin
        w = calm ? 0 : $urandom_range(0, 16);
        if (pending_keys.size() == 0) begin
          $error("unexpected result key=%h", out_key);
          fail_count++;
        end else begin
          e = pending_keys.pop_front();
          if (out_key !== e.key) begin
            $error("key expected %h actual %h", e.key, out_key);
            fail_count++;
          end
          if (out_key_chars !== e.chars) begin
            $error("key_chars expected %0d actual %0d", e.chars, out_key_chars);
            fail_count++;
          end
          if (out_last !== e.last) begin
            $error("last expected %0d actual %0d", e.last, out_last);
            fail_count++;
          end
        end
      end
      rx_wait <= w;
      out_ready <= (w == 0) && !rx_hold;
    end
  end

  initial begin
    int k;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = icg_pkg::REG_KEY_LEN;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_command = icg_pkg::CMD_WRITE;
    in_table_select = '0;
    in_prev_two_index = '0;
    in_prev_one_index = '0;
    in_slot = '0;
    in_digit_index = '0;
    in_value = '0;
    rx_hold = 1'b0;
    calm = 0;
    fail_count = 0;
    cycles = 0;
    len_reg = '0;
    fixed_reg = '0;
    count_reg = '0;
    for (k = 0; k < 8; k++) digits[k] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_random();
    test_backpressure();
    drain();
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
